// ===== rtl/core/fvn_pkg.sv =====
// constants and types for the fractal value noise pipeline
package fvn_pkg;

    localparam int OUT_W    = 48;
    localparam int POS_FRAC = 24;
    localparam int HASH_W   = 31;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 32;

    localparam logic [HASH_W-1:0] K_SEED = 31'd797;
    localparam logic [HASH_W-1:0] K_X    = 31'd1277;
    localparam logic [HASH_W-1:0] K_Y    = 31'd7193;
    localparam logic [HASH_W-1:0] K_H1   = 31'd15731;
    localparam logic [HASH_W-1:0] K_H2   = 31'd789221;
    localparam logic [HASH_W-1:0] K_H3   = 31'd1376312589;
    localparam int                HASH_SHIFT = 13;
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 48'sh8000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED     = 3'd0,
        CFG_OCTAVES  = 3'd1,
        CFG_GAIN     = 3'd2,
        CFG_PERSIST  = 3'd3,
        CFG_INV_X    = 3'd4,
        CFG_INV_Y    = 3'd5
    } t_cfg_idx;

endpackage

// ===== rtl/core/fractal_value_noise_2d.sv =====
// fractal value noise: 16-stage pipeline, all octaves in parallel lanes
// One sample (x, y) enters per cycle while o_ready is high; its noise value is registered
// through every stage on its way to the output. Empty stages collapse, so a stalled output still lets
// new samples fill the pipeline. Each octave has its own lane of hash, bilinear blend and
// weighting; one 32x32 position multiply per axis feeds all lanes. Octave weights are
// registers derived from gain and persistence; after reset and after any register write
// the input holds o_ready low while they settle.
module fractal_value_noise_2d #(
    parameter int MAX_OCTAVES = 8,
    parameter int FRAC_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fvn_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fvn_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [31:0]                i_sample_x,
    input  logic signed [31:0]                i_sample_y,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [fvn_pkg::OUT_W-1:0]  o_noise_value
);
    import fvn_pkg::*;

    localparam int NST    = 16;
    localparam int MO     = MAX_OCTAVES;
    localparam int AW     = 16 + MO;
    localparam int WW     = 31 + MO;
    localparam int HW     = WW - 30;
    localparam int TW     = WW + 1;
    localparam int LW     = 34 + FRAC_BITS;
    localparam int NG     = (MO + 3) / 4;
    localparam int SUMR   = WW + 4 + $clog2(MO + 1);
    localparam int SUMW   = (SUMR > OUT_W + 1) ? SUMR : OUT_W + 1;
    localparam int CNTW   = $clog2(MO + 1);
    localparam int SETW   = $clog2(MO + 3);
    localparam logic [SETW-1:0] SETTLE = SETW'(MO + 2);
    localparam logic signed [SUMW-1:0] SAT_HI = SUMW'(OUT_MAX);
    localparam logic signed [SUMW-1:0] SAT_LO = SUMW'(OUT_MIN);

    // configuration registers
    logic [31:0] r_seed, r_gain, r_inv_x, r_inv_y;
    logic [3:0]  r_octaves;
    logic [16:0] r_pers;
    logic [SETW-1:0] r_settle;

    // derived from configuration
    logic [HASH_W-1:0] r_sb;
    logic [31:0]       r_gmag;
    logic              r_gneg;
    logic [AW-1:0]     r_amp [MO];
    logic [WW-1:0]     r_w   [MO];
    logic [AW-1:0]     n_amp [MO];
    logic [WW-1:0]     n_w   [MO];
    logic [CNTW-1:0]   cnt;

    // handshake
    logic [NST:1] r_vld;
    logic [NST:1] en;

    // stage payload
    logic signed [64:0] n_px, n_py;
    logic [63:0]        r_px, r_py;
    logic [HASH_W-1:0]  n_mx [MO], n_my [MO], r_mx [MO], r_my [MO];
    logic [FRAC_BITS-1:0] n_u [MO], n_v [MO];
    logic [FRAC_BITS-1:0] r_u [2:6][MO];
    logic [FRAC_BITS-1:0] r_v [2:8][MO];
    logic [HASH_W-1:0]  n_h [MO][4], r_h3 [MO][4];
    logic [HASH_W-1:0]  n_sq [MO][4], r_sq4 [MO][4], r_n4 [MO][4];
    logic [HASH_W-1:0]  n_t [MO][4], r_t5 [MO][4], r_n5 [MO][4];
    logic signed [31:0] n_p [MO][4], r_p6 [MO][4];
    logic signed [LW-1:0] n_l7 [MO][2], r_l7 [MO][2];
    logic signed [31:0] r_a7 [MO][2];
    logic signed [31:0] n_r8 [MO][2], r_r8 [MO][2];
    logic signed [LW-1:0] n_l9 [MO], r_l9 [MO];
    logic signed [31:0] r_a9 [MO];
    logic signed [31:0] n_nv [MO], r_nv10 [MO];
    logic [30:0]        n_nmag [MO], r_nmag11 [MO];
    logic               r_nneg11 [MO];
    logic [HW+30:0]     n_phi [MO], r_phi12 [MO];
    logic [60:0]        n_plo [MO], r_plo12 [MO];
    logic               r_sgn12 [MO];
    logic signed [TW-1:0] n_term [MO], r_term13 [MO];
    logic signed [SUMW-1:0] n_grp [NG], r_grp14 [NG];
    logic signed [SUMW-1:0] n_sum, r_sum15;
    logic signed [OUT_W-1:0] n_out, r_out;

    // bubble-collapsing stage enables
    always_comb begin
        en[NST] = ~r_vld[NST] | i_ready;
        for (int s = NST - 1; s >= 1; s--) begin
            en[s] = ~r_vld[s] | en[s+1];
        end
    end

    assign o_ready       = en[1] & (r_settle == '0);
    assign o_valid       = r_vld[NST];
    assign o_noise_value = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_settle  <= SETTLE;
            r_seed    <= 32'd0;
            r_octaves <= 4'd1;
            r_gain    <= 32'd65536;
            r_pers    <= 17'd32768;
            r_inv_x   <= 32'd16777216;
            r_inv_y   <= 32'd16777216;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_valid & o_ready;
            end
            for (int s = 2; s <= NST; s++) begin
                if (en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
            if (i_cfg_we) begin
                r_settle <= SETTLE;
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_SEED:    r_seed    <= i_cfg_data;
                    CFG_OCTAVES: r_octaves <= i_cfg_data[3:0];
                    CFG_GAIN:    r_gain    <= i_cfg_data;
                    CFG_PERSIST: r_pers    <= i_cfg_data[16:0];
                    CFG_INV_X:   r_inv_x   <= i_cfg_data;
                    CFG_INV_Y:   r_inv_y   <= i_cfg_data;
                    default: ;
                endcase
            end else if (r_settle != '0) begin
                r_settle <= r_settle - SETW'(1);
            end
        end
    end

    // octave weights: amp chain and gain scaling, one multiply per register
    always_comb begin
        logic [AW+16:0] ap;
        logic [AW+31:0] wp;
        n_amp[0] = AW'(65536);
        for (int k = 1; k < MO; k++) begin
            ap = r_amp[k-1] * r_pers;
            n_amp[k] = ap[16 +: AW];
        end
        for (int k = 0; k < MO; k++) begin
            wp = r_gmag * r_amp[k];
            n_w[k] = wp[16 +: WW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sb   <= HASH_W'(r_seed[HASH_W-1:0] * K_SEED);
        r_gneg <= r_gain[31];
        r_gmag <= r_gain[31] ? (~r_gain + 32'd1) : r_gain;
        r_amp  <= n_amp;
        r_w    <= n_w;
    end

    assign cnt = (int'(r_octaves) > MO) ? CNTW'(MO) : CNTW'(r_octaves);

    // datapath
    assign n_px = i_sample_x * $signed({1'b0, r_inv_x});
    assign n_py = i_sample_y * $signed({1'b0, r_inv_y});

    always_comb begin
        logic [63:0] shx, shy;
        logic [HASH_W-1:0] base, n0;
        for (int k = 0; k < MO; k++) begin
            shx = r_px << k;
            shy = r_py << k;
            n_mx[k] = HASH_W'(shx[POS_FRAC +: HASH_W] * K_X);
            n_my[k] = HASH_W'(shy[POS_FRAC +: HASH_W] * K_Y);
            n_u[k]  = shx[POS_FRAC - FRAC_BITS +: FRAC_BITS];
            n_v[k]  = shy[POS_FRAC - FRAC_BITS +: FRAC_BITS];
        end
        // corners in order: (cx,cy) (cx+1,cy) (cx,cy+1) (cx+1,cy+1)
        for (int k = 0; k < MO; k++) begin
            base = r_sb + HASH_W'(K_SEED * HASH_W'(k)) + r_mx[k] + r_my[k];
            for (int c = 0; c < 4; c++) begin
                n0 = base + ((c % 2 == 1) ? K_X : '0) + ((c >= 2) ? K_Y : '0);
                n_h[k][c] = (n0 >> HASH_SHIFT) ^ n0;
                n_sq[k][c] = HASH_W'(r_h3[k][c] * r_h3[k][c]);
                n_t[k][c]  = HASH_W'(r_sq4[k][c] * K_H1) + K_H2;
                n_p[k][c]  = ONE_Q30
                           - $signed({1'b0, HASH_W'(r_n5[k][c] * r_t5[k][c]) + K_H3});
            end
        end
    end

    always_comb begin
        logic signed [32:0] d;
        logic signed [LW-1:0] fl;
        for (int k = 0; k < MO; k++) begin
            for (int r = 0; r < 2; r++) begin
                d = 33'(r_p6[k][2*r+1]) - 33'(r_p6[k][2*r]);
                n_l7[k][r] = LW'(d * $signed({1'b0, r_u[6][k]}));
                fl = r_l7[k][r] >>> FRAC_BITS;
                n_r8[k][r] = r_a7[k][r] + fl[31:0];
            end
            d = 33'(r_r8[k][1]) - 33'(r_r8[k][0]);
            n_l9[k] = LW'(d * $signed({1'b0, r_v[8][k]}));
            fl = r_l9[k] >>> FRAC_BITS;
            n_nv[k] = r_a9[k] + fl[31:0];
            n_nmag[k] = r_nv10[k][31] ? 31'(-r_nv10[k]) : r_nv10[k][30:0];
            n_phi[k] = r_w[k][WW-1:30] * r_nmag11[k];
            n_plo[k] = r_w[k][29:0] * r_nmag11[k];
        end
    end

    always_comb begin
        logic [WW-1:0] tmag;
        for (int k = 0; k < MO; k++) begin
            tmag = WW'(r_phi12[k] + (r_plo12[k] >> 30));
            if (CNTW'(k) >= cnt) begin
                n_term[k] = '0;
            end else if (r_sgn12[k]) begin
                n_term[k] = -$signed({1'b0, tmag});
            end else begin
                n_term[k] = $signed({1'b0, tmag});
            end
        end
        for (int g = 0; g < NG; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < 4; j++) begin
                if (g * 4 + j < MO) begin
                    n_grp[g] = n_grp[g] + SUMW'(r_term13[g*4+j]);
                end
            end
        end
        n_sum = '0;
        for (int g = 0; g < NG; g++) begin
            n_sum = n_sum + r_grp14[g];
        end
        if (r_sum15 > SAT_HI) begin
            n_out = OUT_MAX;
        end else if (r_sum15 < SAT_LO) begin
            n_out = OUT_MIN;
        end else begin
            n_out = r_sum15[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_px <= n_px[63:0];
            r_py <= n_py[63:0];
        end
        if (en[2]) begin
            r_mx   <= n_mx;
            r_my   <= n_my;
            r_u[2] <= n_u;
            r_v[2] <= n_v;
        end
        for (int s = 3; s <= 6; s++) begin
            if (en[s]) begin
                r_u[s] <= r_u[s-1];
            end
        end
        for (int s = 3; s <= 8; s++) begin
            if (en[s]) begin
                r_v[s] <= r_v[s-1];
            end
        end
        if (en[3]) begin
            r_h3 <= n_h;
        end
        if (en[4]) begin
            r_sq4 <= n_sq;
            r_n4  <= r_h3;
        end
        if (en[5]) begin
            r_t5 <= n_t;
            r_n5 <= r_n4;
        end
        if (en[6]) begin
            r_p6 <= n_p;
        end
        if (en[7]) begin
            r_l7 <= n_l7;
            for (int k = 0; k < MO; k++) begin
                r_a7[k][0] <= r_p6[k][0];
                r_a7[k][1] <= r_p6[k][2];
            end
        end
        if (en[8]) begin
            r_r8 <= n_r8;
        end
        if (en[9]) begin
            r_l9 <= n_l9;
            for (int k = 0; k < MO; k++) begin
                r_a9[k] <= r_r8[k][0];
            end
        end
        if (en[10]) begin
            r_nv10 <= n_nv;
        end
        if (en[11]) begin
            r_nmag11 <= n_nmag;
            for (int k = 0; k < MO; k++) begin
                r_nneg11[k] <= r_nv10[k][31];
            end
        end
        if (en[12]) begin
            r_phi12 <= n_phi;
            r_plo12 <= n_plo;
            for (int k = 0; k < MO; k++) begin
                r_sgn12[k] <= r_nneg11[k] ^ r_gneg;
            end
        end
        if (en[13]) begin
            r_term13 <= n_term;
        end
        if (en[14]) begin
            r_grp14 <= n_grp;
        end
        if (en[15]) begin
            r_sum15 <= n_sum;
        end
        if (en[16]) begin
            r_out <= n_out;
        end
    end

endmodule
